FILE: rtl/hex_record_line_encoder_macros.svh
// Assertion macros used by the port-level checker of the record line encoder.
`ifndef HEX_RECORD_LINE_ENCODER_MACROS_SVH
`define HEX_RECORD_LINE_ENCODER_MACROS_SVH

// The antecedent and the consequent hold in the same cycle.
`define HRLE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define HRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/hrle_pkg.sv
// Types, constants and the helper function of the hex record line encoder.
package hrle_pkg;

	localparam int LEN_W     = 6;
	localparam int LINE_BASE = 12;

	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_ALPHA   = 8'h41;
	localparam logic [7:0] RECORD_TYPE  = 8'h00;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COLON,
		ST_COUNT,
		ST_ADDR_HI,
		ST_ADDR_LO,
		ST_TYPE,
		ST_DATA,
		ST_CSUM,
		ST_NEWLINE
	} hrle_state_t;

	typedef enum logic [2:0] {
		SRC_COLON,
		SRC_COUNT,
		SRC_ADDR_HI,
		SRC_ADDR_LO,
		SRC_TYPE,
		SRC_DATA,
		SRC_CSUM,
		SRC_NEWLINE
	} hrle_src_t;

	typedef struct packed {
		logic      load;
		logic      emit;
		hrle_src_t src;
		logic      low_nib;
	} hrle_cmd_t;

	typedef struct packed {
		logic out_free;
		logic data_done;
		logic data_last;
	} hrle_sts_t;

	// Upper-case ASCII hex digit for one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] res;
		if (nib < 4'd10) begin
			res = CHAR_ZERO + {4'd0, nib};
		end else begin
			res = CHAR_ALPHA + {4'd0, nib} - 8'd10;
		end
		return res;
	endfunction

endpackage

FILE: rtl/hex_record_line_encoder.sv
// Top level of the Intel HEX data record line encoder.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata: start_address, byte_count, data_bytes_low, data_bytes_high
//   m_axis   out        tdata: line_char, line_length; tlast: last_char
//
// A record request of N data bytes (N saturated to MAX_DATA_BYTES) produces a line of
// 12 + 2 * N characters, one character per cycle while the sink keeps up.
// The request is taken in an idle cycle; the sequencer then writes the characters of the
// line one by one into the single output register and takes no new request until it
// has handed the final newline to that register.
// The next request is accepted while the final newline still waits in the output register.
// When the sink stalls, the sequencer halts and the waiting character holds unchanged.
// Reset clears the sequencer and the output valid flag; no request is in flight afterwards.
module hex_record_line_encoder
	import hrle_pkg::*;
#(
	parameter int MAX_DATA_BYTES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// From bit 0: start_address[15:0], byte_count[4:0], data_bytes_low[63:0],
	// data_bytes_high[63:0], then three zero bits of padding.
	input  logic [151:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// From bit 0: line_char[7:0], line_length[5:0], then two zero bits of padding.
	output logic [15:0]  m_axis_tdata,
	output logic         m_axis_tlast
);

	hrle_cmd_t        cmd;
	hrle_sts_t        sts;
	logic [7:0]       line_char;
	logic [LEN_W-1:0] line_length;

	// The controller only steps through the fields of the line; all values live in
	// the datapath, which also owns the output register.
	hrle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hrle_dp #(
		.MAX_DATA_BYTES (MAX_DATA_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.start_address   (s_axis_tdata[15:0]),
		.byte_count      (s_axis_tdata[20:16]),
		.data_bytes_low  (s_axis_tdata[84:21]),
		.data_bytes_high (s_axis_tdata[148:85]),
		.cmd             (cmd),
		.sts             (sts),
		.out_ready       (m_axis_tready),
		.out_valid       (m_axis_tvalid),
		.line_char       (line_char),
		.last_char       (m_axis_tlast),
		.line_length     (line_length)
	);

	// The padding bits of the output are tied to zero.
	assign m_axis_tdata = {2'b00, line_length, line_char};

endmodule

FILE: rtl/hrle_ctrl.sv
// Sequencing state machine of the hex record line encoder.
module hrle_ctrl
	import hrle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  hrle_sts_t sts,
	output hrle_cmd_t cmd
);

	hrle_state_t state_q, state_d;
	logic        nib_q, nib_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nib_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			nib_q   <= nib_d;
		end
	end

	// Next state: each byte field takes two characters, high nibble first.
	always_comb begin
		hrle_state_t follow;
		state_d = state_q;
		nib_d   = nib_q;
		case (state_q)
			ST_COUNT:   follow = ST_ADDR_HI;
			ST_ADDR_HI: follow = ST_ADDR_LO;
			ST_ADDR_LO: follow = ST_TYPE;
			ST_TYPE:    follow = sts.data_done ? ST_CSUM : ST_DATA;
			ST_DATA:    follow = sts.data_last ? ST_CSUM : ST_DATA;
			ST_CSUM:    follow = ST_NEWLINE;
			default:    follow = ST_IDLE;
		endcase
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_COLON;
					nib_d   = 1'b0;
				end
			end
			ST_COLON: begin
				if (sts.out_free) begin
					state_d = ST_COUNT;
				end
			end
			ST_NEWLINE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_COUNT, ST_ADDR_HI, ST_ADDR_LO, ST_TYPE, ST_DATA, ST_CSUM: begin
				if (sts.out_free) begin
					nib_d = !nib_q;
					if (nib_q) begin
						state_d = follow;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		cmd.load    = in_valid && (state_q == ST_IDLE);
		cmd.emit    = (state_q != ST_IDLE) && sts.out_free;
		cmd.low_nib = nib_q;
		case (state_q)
			ST_COUNT:   cmd.src = SRC_COUNT;
			ST_ADDR_HI: cmd.src = SRC_ADDR_HI;
			ST_ADDR_LO: cmd.src = SRC_ADDR_LO;
			ST_TYPE:    cmd.src = SRC_TYPE;
			ST_DATA:    cmd.src = SRC_DATA;
			ST_CSUM:    cmd.src = SRC_CSUM;
			ST_NEWLINE: cmd.src = SRC_NEWLINE;
			default:    cmd.src = SRC_COLON;
		endcase
	end

endmodule

FILE: rtl/hrle_dp.sv
// Datapath of the hex record line encoder: record fields, checksum and output register.
module hrle_dp
	import hrle_pkg::*;
#(
	parameter int MAX_DATA_BYTES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [15:0]      start_address,
	input  logic [4:0]       byte_count,
	input  logic [63:0]      data_bytes_low,
	input  logic [63:0]      data_bytes_high,
	input  hrle_cmd_t        cmd,
	output hrle_sts_t        sts,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [7:0]       line_char,
	output logic             last_char,
	output logic [LEN_W-1:0] line_length
);

	localparam int DATA_W = 8 * MAX_DATA_BYTES;
	localparam int CNT_W  = $clog2(MAX_DATA_BYTES + 1);

	logic [15:0]       addr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  left_q;
	logic [DATA_W-1:0] data_q;
	logic [7:0]        sum_q;
	logic [LEN_W-1:0]  len_q;

	logic              out_valid_q;
	logic [7:0]        out_char_q;
	logic              out_last_q;
	logic [LEN_W-1:0]  out_len_q;

	logic [CNT_W-1:0]  cnt_sat;
	logic [127:0]      data_in;
	logic [7:0]        cur_byte;
	logic [3:0]        cur_nib;
	logic [7:0]        cur_char;
	logic              out_free;

	assign cnt_sat = (byte_count > 5'(MAX_DATA_BYTES)) ? CNT_W'(MAX_DATA_BYTES)
	                                                   : CNT_W'(byte_count);
	assign data_in = {data_bytes_high, data_bytes_low};
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		case (cmd.src)
			SRC_COUNT:   cur_byte = 8'(cnt_q);
			SRC_ADDR_HI: cur_byte = addr_q[15:8];
			SRC_ADDR_LO: cur_byte = addr_q[7:0];
			SRC_DATA:    cur_byte = data_q[7:0];
			SRC_CSUM:    cur_byte = ~sum_q + 8'd1;
			default:     cur_byte = RECORD_TYPE;
		endcase
		cur_nib = cmd.low_nib ? cur_byte[3:0] : cur_byte[7:4];
		case (cmd.src)
			SRC_COLON:   cur_char = CHAR_COLON;
			SRC_NEWLINE: cur_char = CHAR_NEWLINE;
			default:     cur_char = hex_char(cur_nib);
		endcase
	end

	// Record fields and running checksum.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= start_address;
			cnt_q  <= cnt_sat;
			left_q <= cnt_sat;
			data_q <= data_in[DATA_W-1:0];
			sum_q  <= 8'(cnt_sat) + start_address[15:8] + start_address[7:0];
			len_q  <= LEN_W'(LINE_BASE) + (LEN_W'(cnt_sat) << 1);
		end else if (cmd.emit && (cmd.src == SRC_DATA)) begin
			if (cmd.low_nib) begin
				data_q <= data_q >> 8;
				left_q <= left_q - CNT_W'(1);
			end else begin
				sum_q <= sum_q + data_q[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_char_q <= cur_char;
			out_last_q <= (cmd.src == SRC_NEWLINE);
			out_len_q  <= len_q;
		end
	end

	assign sts.out_free  = out_free;
	assign sts.data_done = (left_q == '0);
	assign sts.data_last = (left_q == CNT_W'(1));

	assign out_valid   = out_valid_q;
	assign line_char   = out_char_q;
	assign last_char   = out_last_q;
	assign line_length = out_len_q;

endmodule

FILE: rtl/hrle_checker.sv
// Port-level checker of the hex record line encoder and its bind.
`include "hex_record_line_encoder_macros.svh"

module hrle_checker
	import hrle_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	`HRLE_ASSERT_SAME(a_last_is_newline, m_axis_tvalid && m_axis_tlast, m_axis_tdata[7:0] == CHAR_NEWLINE, "final character is not a newline")
	`HRLE_ASSERT_SAME(a_length_legal, m_axis_tvalid, !m_axis_tdata[8] && (m_axis_tdata[13:8] >= 6'd12) && (m_axis_tdata[13:8] <= 6'd44), "line length out of range")
	`HRLE_ASSERT_NEXT(a_no_gap_in_line, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside a line")
	`HRLE_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken during a line")
	`HRLE_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled character changed")

endmodule

bind hex_record_line_encoder hrle_checker u_hrle_checker (.*);
